// ===== sv/assert_macros.svh =====
// assertion macros shared by the matcher rtl
// expects clk_i and rst_ni in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define BQL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define BQL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bql_pkg.sv =====
// shared types, constants and helpers of the q-gram long-pattern matcher
// no dependencies
`timescale 1ns / 1ps

package bql_pkg;

  localparam int unsigned Q         = 7;
  localparam int unsigned S         = 2;
  localparam int unsigned TAB_AW    = Q * S;
  localparam int unsigned PAT_AW    = 8;
  localparam int unsigned TXT_AW    = 12;
  localparam int unsigned WORD_BITS = 32;
  localparam logic [8:0]  MAX_PAT   = 9'd256;
  localparam logic [12:0] MAX_TXT   = 13'd4096;
  localparam logic [8:0]  PLEN_RST  = 9'd8;

  typedef enum logic [1:0] {
    OP_PAT   = 2'd0,
    OP_TXT   = 2'd1,
    OP_FETCH = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ES_IDLE,
    ES_CLR,
    ES_B_RD,
    ES_B_GRAM,
    ES_B_WR,
    ES_WIN,
    ES_G_RD,
    ES_G_USE,
    ES_V_LOAD,
    ES_LOOP,
    ES_K_NEXT,
    ES_T_RD,
    ES_T_USE,
    ES_T_VEC,
    ES_C_RD,
    ES_C_CHK,
    ES_P_RD,
    ES_P_CMP,
    ES_END
  } eng_state_e;

  typedef struct packed {
    logic              fetch;
    logic              invalidate;
    logic              pat_we;
    logic [PAT_AW-1:0] pat_waddr;
    logic [7:0]        pat_wdata;
    logic              txt_we;
    logic [TXT_AW-1:0] txt_waddr;
    logic [7:0]        txt_wdata;
    logic [8:0]        m_len;
    logic [12:0]       n_len;
  } eng_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [TXT_AW-1:0] pos;
  } eng_res_t;

  // fold one byte into the condensed gram
  function automatic logic [TAB_AW-1:0] gram_step(input logic [TAB_AW-1:0] g,
                                                  input logic [7:0] b);
    logic [TAB_AW-1:0] sh;
    sh = {g[TAB_AW-S-1:0], {S{1'b0}}};
    return sh + {{(TAB_AW-8){1'b0}}, b};
  endfunction

endpackage

// ===== sv/bql_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bql_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/bql_engine.sv =====
// search engine: pattern, text, filter table and checked-position memories
// plus the sequencer that clears, builds, scans and verifies; uses bql_pkg, bql_ram
`timescale 1ns / 1ps

module bql_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bql_pkg::eng_ctrl_t ctrl_i,
  output bql_pkg::eng_res_t  res_o,
  output logic               idle_o
);

  bql_pkg::eng_state_e state_q, state_d, resume_q, resume_d, ret_q, ret_d;
  logic        built_q, built_d;
  logic [13:0] clr_q, clr_d;
  logic [12:0] i_q, i_d, j_q, j_d, k_q, k_d, first_q, first_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [31:0] vec_q, vec_d;
  logic [13:0] gram_q, gram_d;
  logic [4:0]  r_q, r_d;

  // ram ports
  logic        tab_we;
  logic [13:0] tab_waddr, tab_raddr;
  logic [31:0] tab_wdata, tab_rdata;
  logic        chk_we, chk_wdata, chk_rdata;
  logic [11:0] chk_waddr, chk_raddr;
  logic [7:0]  pat_raddr, pat_rdata, txt_rdata;
  logic [11:0] txt_raddr;

  // derived lengths
  logic [8:0]  m_eff, mq1;
  logic [5:0]  w;
  logic [4:0]  top_idx, r_init;
  logic [13:0] gram_new;

  assign m_eff   = (ctrl_i.m_len > bql_pkg::MAX_PAT) ? bql_pkg::MAX_PAT : ctrl_i.m_len;
  assign mq1     = m_eff - 9'(bql_pkg::Q - 1);
  assign w       = (m_eff < 9'(bql_pkg::WORD_BITS)) ? m_eff[5:0] : 6'(bql_pkg::WORD_BITS);
  assign top_idx = 5'(w - 6'd1);
  // first bit position of the build: (padded - (m-1)) mod w
  assign r_init  = (m_eff < 9'(bql_pkg::WORD_BITS)) ? 5'd1 : 5'(6'd33 - {1'b0, m_eff[4:0]});
  assign gram_new = bql_pkg::gram_step(gram_q,
                      (state_q == bql_pkg::ES_B_GRAM) ? pat_rdata : txt_rdata);

  bql_ram #(.AW(bql_pkg::PAT_AW), .DW(8)) u_pat (
    .clk_i, .we_i(ctrl_i.pat_we), .waddr_i(ctrl_i.pat_waddr), .wdata_i(ctrl_i.pat_wdata),
    .raddr_i(pat_raddr), .rdata_o(pat_rdata)
  );
  bql_ram #(.AW(bql_pkg::TXT_AW), .DW(8)) u_txt (
    .clk_i, .we_i(ctrl_i.txt_we), .waddr_i(ctrl_i.txt_waddr), .wdata_i(ctrl_i.txt_wdata),
    .raddr_i(txt_raddr), .rdata_o(txt_rdata)
  );
  bql_ram #(.AW(bql_pkg::TAB_AW), .DW(bql_pkg::WORD_BITS)) u_tab (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(tab_wdata),
    .raddr_i(tab_raddr), .rdata_o(tab_rdata)
  );
  bql_ram #(.AW(bql_pkg::TXT_AW), .DW(1)) u_chk (
    .clk_i, .we_i(chk_we), .waddr_i(chk_waddr), .wdata_i(chk_wdata),
    .raddr_i(chk_raddr), .rdata_o(chk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bql_pkg::ES_IDLE;
      resume_q <= bql_pkg::ES_END;
      ret_q    <= bql_pkg::ES_END;
      built_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      ret_q    <= ret_d;
      built_q  <= built_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q   <= clr_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    first_q <= first_d;
    cnt_q   <= cnt_d;
    vec_q   <= vec_d;
    gram_q  <= gram_d;
    r_q     <= r_d;
  end

  always_comb begin
    state_d   = state_q;
    resume_d  = resume_q;
    ret_d     = ret_q;
    built_d   = built_q;
    clr_d     = clr_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    first_d   = first_q;
    cnt_d     = cnt_q;
    vec_d     = vec_q;
    gram_d    = gram_q;
    r_d       = r_q;
    tab_we    = 1'b0;
    tab_waddr = clr_q;
    tab_wdata = '0;
    tab_raddr = gram_new;
    chk_we    = 1'b0;
    chk_waddr = k_q[11:0];
    chk_wdata = 1'b1;
    chk_raddr = k_q[11:0];
    pat_raddr = cnt_q[7:0];
    txt_raddr = 12'(k_q + {4'd0, cnt_q});
    res_o     = '0;

    case (state_q)
      bql_pkg::ES_IDLE: begin
        if (ctrl_i.invalidate) begin
          built_d = 1'b0;
        end else if (ctrl_i.fetch) begin
          if (built_q) begin
            state_d = resume_q;
          end else begin
            built_d = 1'b1;
            if (m_eff <= 9'(bql_pkg::Q) || ctrl_i.n_len < {4'd0, m_eff}) begin
              state_d = bql_pkg::ES_END;
            end else begin
              clr_d   = '0;
              state_d = bql_pkg::ES_CLR;
            end
          end
        end
      end

      // one table word a cycle; checked bits ride along on the low addresses
      bql_pkg::ES_CLR: begin
        tab_we    = 1'b1;
        chk_we    = (clr_q[13:12] == 2'd0);
        chk_waddr = clr_q[11:0];
        chk_wdata = 1'b0;
        clr_d     = clr_q + 14'd1;
        if (&clr_q) begin
          i_d     = {4'd0, m_eff} - 13'd1;
          gram_d  = '0;
          r_d     = r_init;
          state_d = bql_pkg::ES_B_RD;
        end
      end

      bql_pkg::ES_B_RD: begin
        pat_raddr = i_q[7:0];
        state_d   = bql_pkg::ES_B_GRAM;
      end

      bql_pkg::ES_B_GRAM: begin
        gram_d = gram_new;
        if (i_q < {4'd0, mq1}) begin
          state_d = bql_pkg::ES_B_WR;
        end else begin
          r_d = ({1'b0, r_q} + 6'd1 == w) ? 5'd0 : r_q + 5'd1;
          i_d = i_q - 13'd1;
          state_d = bql_pkg::ES_B_RD;
        end
      end

      // read-modify-write of the table word read in the previous cycle
      bql_pkg::ES_B_WR: begin
        tab_we    = 1'b1;
        tab_waddr = gram_q;
        tab_wdata = tab_rdata | (32'd1 << r_q);
        r_d       = ({1'b0, r_q} + 6'd1 == w) ? 5'd0 : r_q + 5'd1;
        i_d       = i_q - 13'd1;
        state_d   = bql_pkg::ES_B_RD;
        if (i_q == 13'd0) begin
          i_d     = {4'd0, mq1} - 13'd1;
          state_d = bql_pkg::ES_WIN;
        end
      end

      bql_pkg::ES_WIN: begin
        if ({1'b0, i_q} + 14'(bql_pkg::Q) > {1'b0, ctrl_i.n_len}) begin
          state_d = bql_pkg::ES_END;
        end else begin
          first_d = i_q - {4'd0, mq1} + 13'd1;
          j_d     = i_q + 13'(bql_pkg::Q - 1);
          gram_d  = '0;
          state_d = bql_pkg::ES_G_RD;
        end
      end

      bql_pkg::ES_G_RD: begin
        txt_raddr = j_q[11:0];
        state_d   = bql_pkg::ES_G_USE;
      end

      bql_pkg::ES_G_USE: begin
        gram_d = gram_new;
        if (j_q == i_q) begin
          state_d = bql_pkg::ES_V_LOAD;
        end else begin
          j_d     = j_q - 13'd1;
          state_d = bql_pkg::ES_G_RD;
        end
      end

      bql_pkg::ES_V_LOAD: begin
        vec_d = tab_rdata;
        if (tab_rdata[0]) begin
          k_d     = i_q;
          ret_d   = bql_pkg::ES_LOOP;
          state_d = bql_pkg::ES_C_RD;
        end else begin
          state_d = bql_pkg::ES_LOOP;
        end
      end

      // backward walk through the window
      bql_pkg::ES_LOOP: begin
        if (vec_q != '0 && j_q > first_q) begin
          j_d = j_q - 13'd1;
          if (vec_q[top_idx]) begin
            k_d     = j_q - 13'd1;
            ret_d   = bql_pkg::ES_K_NEXT;
            state_d = bql_pkg::ES_C_RD;
          end else begin
            state_d = bql_pkg::ES_T_RD;
          end
        end else begin
          i_d     = i_q + {4'd0, mq1};
          state_d = bql_pkg::ES_WIN;
        end
      end

      // candidates spaced by w below the current position
      bql_pkg::ES_K_NEXT: begin
        if ({1'b0, k_q} >= {1'b0, first_q} + {8'd0, w}) begin
          k_d     = k_q - {7'd0, w};
          ret_d   = bql_pkg::ES_K_NEXT;
          state_d = bql_pkg::ES_C_RD;
        end else begin
          state_d = bql_pkg::ES_T_RD;
        end
      end

      bql_pkg::ES_T_RD: begin
        txt_raddr = j_q[11:0];
        state_d   = bql_pkg::ES_T_USE;
      end

      bql_pkg::ES_T_USE: begin
        gram_d  = gram_new;
        state_d = bql_pkg::ES_T_VEC;
      end

      bql_pkg::ES_T_VEC: begin
        vec_d   = {vec_q[30:0], 1'b0} & tab_rdata;
        state_d = bql_pkg::ES_LOOP;
      end

      bql_pkg::ES_C_RD: begin
        state_d = bql_pkg::ES_C_CHK;
      end

      // each position is tried once per search
      bql_pkg::ES_C_CHK: begin
        if (chk_rdata) begin
          state_d = ret_q;
        end else begin
          chk_we = 1'b1;
          if ({1'b0, k_q} + {5'd0, m_eff} <= {1'b0, ctrl_i.n_len}) begin
            cnt_d   = '0;
            state_d = bql_pkg::ES_P_RD;
          end else begin
            state_d = ret_q;
          end
        end
      end

      bql_pkg::ES_P_RD: begin
        state_d = bql_pkg::ES_P_CMP;
      end

      bql_pkg::ES_P_CMP: begin
        if (pat_rdata != txt_rdata) begin
          state_d = ret_q;
        end else if (cnt_q == m_eff - 9'd1) begin
          res_o.valid = 1'b1;
          res_o.found = 1'b1;
          res_o.pos   = k_q[11:0];
          resume_d    = ret_q;
          state_d     = bql_pkg::ES_IDLE;
        end else begin
          cnt_d   = cnt_q + 9'd1;
          state_d = bql_pkg::ES_P_RD;
        end
      end

      bql_pkg::ES_END: begin
        res_o.valid = 1'b1;
        resume_d    = bql_pkg::ES_END;
        state_d     = bql_pkg::ES_IDLE;
      end

      default: begin
        state_d = bql_pkg::ES_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == bql_pkg::ES_IDLE);

endmodule

// ===== sv/qgram_bit_parallel_long_matcher_core.sv =====
// top level of the q-gram long-pattern matcher: stream ports, load bookkeeping,
// length register and result register; uses bql_pkg, bql_engine, assert_macros.svh
`timescale 1ns / 1ps

// Loads pattern and text bytes, then answers each fetch request with the next
// verified occurrence in scan order, or with done once the text is exhausted.
// The first fetch after any load, or any length write while the engine is idle,
// clears the 16384-word filter table when the pattern is longer than Q and fits
// the text, one word a cycle (the checked-position bits are cleared in the same
// sweep), then builds it from the pattern bytes. Scanning reads text bytes and
// table words, and verification compares pattern and text bytes one by one, all
// through the single read port of the pattern, text and table memories. Later
// fetches resume where the previous one stopped. Only one request is in work at
// a time; input is not taken while a search runs.

`include "assert_macros.svh"

module qgram_bit_parallel_long_matcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // length register
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,       // pattern_length
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,      // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,      // [1:0] opcode
  input  logic        s_axis_tlast,      // last_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,      // [11:0] match_position, [24:12] match_count, rest 0
  output logic [1:0]  m_axis_tuser       // [0] found, [1] done_res
);

  // length register and load bookkeeping
  logic [8:0]  plen_q, plen_d;
  logic [8:0]  pfill_q, pfill_d;
  logic [12:0] tlen_q, tlen_d;
  logic        p_restart_q, p_restart_d;
  logic        t_closed_q, t_closed_d;
  logic [12:0] found_total_q, found_total_d;

  // result register
  logic        m_valid_q, m_valid_d;
  logic [11:0] m_pos_q, m_pos_d;
  logic [12:0] m_cnt_q, m_cnt_d;
  logic        m_found_q, m_found_d, m_done_q, m_done_d;

  bql_pkg::eng_ctrl_t ctrl;
  bql_pkg::eng_res_t  res;
  logic               eng_idle;
  logic               req_acc;
  bql_pkg::op_e       op;
  logic [8:0]         p_wptr;
  logic [12:0]        t_wptr;

  assign op      = bql_pkg::op_e'(s_axis_tuser);
  // a request waits for the engine; a result may still be pending if it leaves now
  assign s_axis_tready = eng_idle && (!m_valid_q || m_axis_tready);
  assign req_acc = s_axis_tvalid && s_axis_tready;

  // a pattern after a fetch, or text after the marked last byte, starts over
  assign p_wptr = p_restart_q ? 9'd0 : pfill_q;
  assign t_wptr = t_closed_q ? 13'd0 : tlen_q;

  always_comb begin
    plen_d        = plen_q;
    pfill_d       = pfill_q;
    tlen_d        = tlen_q;
    p_restart_d   = p_restart_q;
    t_closed_d    = t_closed_q;
    found_total_d = found_total_q;
    ctrl          = '0;
    ctrl.pat_waddr = p_wptr[7:0];
    ctrl.pat_wdata = s_axis_tdata;
    ctrl.txt_waddr = t_wptr[11:0];
    ctrl.txt_wdata = s_axis_tdata;
    ctrl.m_len     = plen_q;
    ctrl.n_len     = tlen_q;

    if (cfg_we_i) begin
      plen_d          = cfg_wdata_i;
      found_total_d   = '0;
      ctrl.invalidate = 1'b1;
    end

    if (req_acc) begin
      case (op)
        bql_pkg::OP_PAT: begin
          p_restart_d     = 1'b0;
          pfill_d         = p_wptr;
          if (p_wptr < bql_pkg::MAX_PAT) begin
            ctrl.pat_we = 1'b1;
            pfill_d     = p_wptr + 9'd1;
          end
          found_total_d   = '0;
          ctrl.invalidate = 1'b1;
        end
        bql_pkg::OP_TXT: begin
          t_closed_d      = s_axis_tlast;
          tlen_d          = t_wptr;
          if (t_wptr < bql_pkg::MAX_TXT) begin
            ctrl.txt_we = 1'b1;
            tlen_d      = t_wptr + 13'd1;
          end
          found_total_d   = '0;
          ctrl.invalidate = 1'b1;
        end
        bql_pkg::OP_FETCH: begin
          p_restart_d = 1'b1;
          ctrl.fetch  = 1'b1;
        end
        default: begin
          // unused opcode: taken and dropped
        end
      endcase
    end

    // a search that was not built starts counting from zero; the count was
    // already cleared by the load or write that ended the previous search
    if (res.valid && res.found) begin
      found_total_d = found_total_q + 13'd1;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_pos_d   = m_pos_q;
    m_cnt_d   = m_cnt_q;
    m_found_d = m_found_q;
    m_done_d  = m_done_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (res.valid) begin
      m_valid_d = 1'b1;
      m_pos_d   = res.found ? res.pos : 12'd0;
      m_found_d = res.found;
      m_done_d  = !res.found;
      m_cnt_d   = found_total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q        <= bql_pkg::PLEN_RST;
      pfill_q       <= '0;
      tlen_q        <= '0;
      p_restart_q   <= 1'b0;
      t_closed_q    <= 1'b0;
      found_total_q <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      plen_q        <= plen_d;
      pfill_q       <= pfill_d;
      tlen_q        <= tlen_d;
      p_restart_q   <= p_restart_d;
      t_closed_q    <= t_closed_d;
      found_total_q <= found_total_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_pos_q   <= m_pos_d;
    m_cnt_q   <= m_cnt_d;
    m_found_q <= m_found_d;
    m_done_q  <= m_done_d;
  end

  bql_engine u_engine (
    .clk_i,
    .rst_ni,
    .ctrl_i (ctrl),
    .res_o  (res),
    .idle_o (eng_idle)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_cnt_q, m_pos_q};
  assign m_axis_tuser  = {m_done_q, m_found_q};

  // the engine never finishes into an occupied result register
  `BQL_ASSERT_IMP(a_res_slot_free, res.valid, !m_valid_q, "engine result while output busy")
  // a reported match advances the running count by exactly one
  `BQL_ASSERT_NXT(a_count_step, res.valid && res.found,
                  m_cnt_q == $past(found_total_q) + 13'd1, "match count did not step")
  // a match result always carries a nonzero count and never the done flag
  `BQL_ASSERT_IMP(a_found_cnt, m_valid_q && m_found_q, m_cnt_q != 13'd0 && !m_done_q,
                  "match result with bad count or done flag")
  // the engine only leaves idle on a fetch request
  `BQL_ASSERT_NXT(a_eng_start, eng_idle && !ctrl.fetch, eng_idle, "engine started unasked")

endmodule
